// ----- rtl/core/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared constants, codes and controller/datapath interface types of the
// binary max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CHILD_BITS = IDX_BITS + 2;

    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [IDX_BITS-1:0]        t_idx;
    typedef logic [CNT_BITS-1:0]        t_cnt;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load_ins;   // hole at slot count, key held, count up
        logic load_rem;   // read last slot, count down, hole at root
        logic load_v;     // take read data as the moving key
        logic rd_parent;  // read port A addresses the parent of the hole
        logic up_move;    // parent drops into the hole, hole moves up
        logic dn_move;    // chosen child rises into the hole, hole moves down
        logic wr_hole;    // moving key lands in the hole
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic no_child;
        logic up_gt;
        logic take_r;
        logic take_l;
        t_cnt count;
        t_key root;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/bmh_ram.sv -----
// ----------------------------------------------------------------------------
// bmh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/core/bmh_datapath.sv -----
// ----------------------------------------------------------------------------
// bmh_datapath
// Heap storage, entry count, hole position, moving key and cached root,
// with the key compares that steer the sift.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [bmh_pkg::KEY_BITS-1:0] i_key,
    input  wire bmh_pkg::t_dp_cmd i_cmd,
    output bmh_pkg::t_dp_sts     o_sts
);

    import bmh_pkg::*;

    t_cnt r_count;
    t_idx r_pos;
    t_key r_v;
    t_key r_root;

    t_key rd_a;
    t_key rd_b;
    logic [KEY_BITS-1:0] ram_rd_a;
    logic [KEY_BITS-1:0] ram_rd_b;

    t_idx                  w_parent;
    logic [IDX_BITS:0]     w_lc;
    logic [CHILD_BITS-1:0] w_lc_x;
    logic [CHILD_BITS-1:0] w_rc_x;
    logic [CHILD_BITS-1:0] w_cnt_x;
    t_cnt                  w_last;
    logic                  w_rc_in;
    logic                  w_take_r;
    logic                  w_take_l;

    t_idx raddr_a;
    logic we;
    t_key wdata;

    assign w_parent = (r_pos - IDX_BITS'(1)) >> 1;
    assign w_lc     = {r_pos, 1'b1};
    assign w_lc_x   = CHILD_BITS'(w_lc);
    assign w_rc_x   = w_lc_x + CHILD_BITS'(1);
    assign w_cnt_x  = CHILD_BITS'(r_count);
    assign w_last   = r_count - CNT_BITS'(1);

    assign rd_a = t_key'(ram_rd_a);
    assign rd_b = t_key'(ram_rd_b);

    // port A: left child, parent or last slot; port B: right child
    always_comb begin
        priority if (i_cmd.load_rem) begin
            raddr_a = w_last[IDX_BITS-1:0];
        end else if (i_cmd.rd_parent) begin
            raddr_a = w_parent;
        end else begin
            raddr_a = w_lc[IDX_BITS-1:0];
        end
    end

    assign w_rc_in  = w_rc_x < w_cnt_x;
    assign w_take_r = w_rc_in && (rd_b > r_v) && (rd_b > rd_a);
    assign w_take_l = !w_take_r && (w_lc_x < w_cnt_x) && (rd_a > r_v);

    assign we = i_cmd.up_move | i_cmd.dn_move | i_cmd.wr_hole;

    always_comb begin
        priority if (i_cmd.wr_hole) begin
            wdata = r_v;
        end else if (i_cmd.dn_move && w_take_r) begin
            wdata = rd_b;
        end else begin
            wdata = rd_a;
        end
    end

    bmh_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_pos),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (w_rc_x[IDX_BITS-1:0]),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_ins) begin
            r_count <= r_count + CNT_BITS'(1);
        end else if (i_cmd.load_rem) begin
            r_count <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ins) begin
            r_pos <= r_count[IDX_BITS-1:0];
            r_v   <= t_key'(i_key);
        end else if (i_cmd.load_rem) begin
            r_pos <= '0;
        end else if (i_cmd.load_v) begin
            r_v <= rd_a;
        end else if (i_cmd.up_move) begin
            r_pos <= w_parent;
        end else if (i_cmd.dn_move) begin
            r_pos <= w_take_r ? w_rc_x[IDX_BITS-1:0] : w_lc[IDX_BITS-1:0];
        end
        // root is mirrored so the result never needs a memory read
        if (we && r_pos == '0) begin
            r_root <= wdata;
        end
    end

    always_comb begin
        o_sts.full     = r_count == CNT_BITS'(CAPACITY);
        o_sts.empty    = r_count == '0;
        o_sts.pos_zero = r_pos == '0;
        o_sts.no_child = w_lc_x >= w_cnt_x;
        o_sts.up_gt    = r_v > rd_a;
        o_sts.take_r   = w_take_r;
        o_sts.take_l   = w_take_l;
        o_sts.count    = r_count;
        o_sts.root     = r_root;
    end

endmodule

`default_nettype wire

// ----- rtl/core/bmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sequencer of the heap: takes one transaction, walks the sift a level at a
// time and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_op,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [1:0]                        o_status,
    output logic [bmh_pkg::KEY_BITS-1:0]      o_top_key,
    output logic                              o_top_valid,
    output logic [bmh_pkg::CNT_BITS-1:0]      o_count,
    output bmh_pkg::t_dp_cmd                  o_cmd,
    input  wire bmh_pkg::t_dp_sts             i_sts
);

    import bmh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHK,
        S_DN_CMP,
        S_WRITE,
        S_DONE
    } t_state;

    t_state  r_state;
    t_status r_status;
    logic    w_accept;
    logic    w_ins;
    logic    w_load_out;

    assign o_in_ready = r_state == S_IDLE;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ins      = t_op'(i_op) == OP_INSERT;
    assign w_load_out = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_ins = w_accept && w_ins && !i_sts.full;
                o_cmd.load_rem = w_accept && !w_ins && !i_sts.empty;
            end
            S_UP_CHK:  o_cmd.rd_parent = !i_sts.pos_zero;
            S_UP_CMP:  o_cmd.up_move   = i_sts.up_gt;
            S_DN_LOAD: o_cmd.load_v    = 1'b1;
            S_DN_CMP:  o_cmd.dn_move   = i_sts.take_r || i_sts.take_l;
            S_WRITE:   o_cmd.wr_hole   = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            o_out_valid <= 1'b0;
            o_status    <= ST_OK;
            o_top_key   <= '0;
            o_top_valid <= 1'b0;
            o_count     <= '0;
        end else begin
            // a held result leaves on tready unless the next one replaces it
            if (w_load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        priority if (w_ins && i_sts.full) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else if (!w_ins && i_sts.empty) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= w_ins ? S_UP_CHK : S_DN_LOAD;
                        end
                    end
                end
                S_UP_CHK:  r_state <= i_sts.pos_zero ? S_WRITE : S_UP_CMP;
                S_UP_CMP:  r_state <= i_sts.up_gt ? S_UP_CHK : S_WRITE;
                S_DN_LOAD: r_state <= S_DN_CHK;
                S_DN_CHK:  r_state <= i_sts.no_child ? S_WRITE : S_DN_CMP;
                S_DN_CMP: begin
                    r_state <= (i_sts.take_r || i_sts.take_l) ? S_DN_CHK : S_WRITE;
                end
                S_WRITE:   r_state <= S_DONE;
                S_DONE: begin
                    // result payload, loaded with the valid flag
                    if (w_load_out) begin
                        o_status    <= r_status;
                        o_top_key   <= i_sts.empty ? '0 : i_sts.root;
                        o_top_valid <= !i_sts.empty;
                        o_count     <= i_sts.count;
                        r_state     <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/binary_max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Array-based max-heap of signed keys with insert and remove-maximum.
// ----------------------------------------------------------------------------
// One transaction at a time. tuser[0] selects insert (0) or remove maximum (1),
// tdata carries the key. Each transaction gives one result: status in tuser,
// and in tdata the largest key, a non-empty flag and the count after it.
// An insert climbs the key toward the root, a remove sinks the last key from
// the root; the key moves at most 8 levels for an insert, 7 for a remove at
// 256 entries. Each level takes a registered read of the heap RAM and then a
// compare/write step, and a final write puts the key in its slot. A rejected
// insert or a remove on an empty heap goes straight to the result. A new
// transaction is taken while the previous result still waits in the output
// register; its own result then waits until that one is taken.
// No clearing pass: only data from slots below the count is used.
`default_nettype none

module binary_max_heap_priority_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [31:0] key
    input  wire logic        i_s_axis_tuser,  // [0] op
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // [31:0] top_key, [32] top_valid,
                                              // [41:33] count, [47:42] zero
    output logic [1:0]       o_m_axis_tuser   // [1:0] status
);

    import bmh_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    logic [KEY_BITS-1:0] top_key;
    logic                top_valid;
    t_cnt                count;

    bmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_status    (o_m_axis_tuser),
        .o_top_key   (top_key),
        .o_top_valid (top_valid),
        .o_count     (count),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bmh_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_s_axis_tdata),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    assign o_m_axis_tdata = {6'd0, count, top_valid, top_key};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.count <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !(cmd.up_move || cmd.dn_move || cmd.wr_hole))
        else $error("heap written while idle");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (top_valid == (count != '0)))
        else $error("top_valid disagrees with count");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_FULL) |-> count == CNT_BITS'(CAPACITY))
        else $error("insert rejected while heap not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !top_valid) |-> top_key == '0)
        else $error("non-zero key reported on empty heap");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary max-heap priority queue. A software heap
// tracks every accepted insert and remove. Each result on the master side is
// checked field by field against the oldest prediction. Both stream sides
// idle at random, except in the final random mix.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import bmh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        t_status    status;
        t_key       top;
        logic       top_valid;
        t_cnt       count;
    } t_heap_result;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    // software heap, advanced on every accepted transaction
    t_key         heap_mem [CAPACITY];
    int           heap_cnt = 0;
    t_heap_result pending_results [$];

    int mismatches     = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    binary_max_heap_priority_queue DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] key
        .i_s_axis_tuser  (s_tuser),   // [0] op
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] top_key, [32] top_valid,
                                            // [41:33] count, [47:42] zero
        .o_m_axis_tuser  (o_m_axis_tuser)   // [1:0] status
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_heap_result apply_heap_op(t_op op, t_key key);
        t_heap_result r;
        int   pos;
        int   up;
        int   lc;
        int   rc;
        int   nxt;
        t_key tmp;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (heap_cnt >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                heap_mem[heap_cnt] = key;
                pos = heap_cnt;
                heap_cnt++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (!(heap_mem[pos] > heap_mem[up])) break;
                    tmp = heap_mem[pos];
                    heap_mem[pos] = heap_mem[up];
                    heap_mem[up] = tmp;
                    pos = up;
                end
            end
        end else if (heap_cnt == 0) begin
            r.status = ST_EMPTY;
        end else begin
            heap_mem[0] = heap_mem[heap_cnt - 1];
            heap_cnt--;
            pos = 0;
            while (pos < heap_cnt) begin
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                // right child only when it beats both parent and left child
                if (rc < heap_cnt && heap_mem[rc] > heap_mem[pos] &&
                        heap_mem[rc] > heap_mem[lc]) begin
                    nxt = rc;
                end else if (lc < heap_cnt && heap_mem[lc] > heap_mem[pos]) begin
                    nxt = lc;
                end else begin
                    break;
                end
                tmp = heap_mem[nxt];
                heap_mem[nxt] = heap_mem[pos];
                heap_mem[pos] = tmp;
                pos = nxt;
            end
        end
        r.top       = (heap_cnt != 0) ? heap_mem[0] : '0;
        r.top_valid = (heap_cnt != 0);
        r.count     = t_cnt'(heap_cnt);
        return r;
    endfunction

    // predict on the slave side, check on the master side
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready)
                pending_results.push_back(apply_heap_op(t_op'(s_tuser), t_key'(s_tdata)));
            if (o_m_axis_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: tuser %0d tdata %h",
                             $time, o_m_axis_tuser, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (t_status'(o_m_axis_tuser) != want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, o_m_axis_tuser);
                        mismatches++;
                    end
                    if (t_key'(o_m_axis_tdata[31:0]) != want.top) begin
                        $display("%0t: top_key mismatch: expected %0d, got %0d",
                                 $time, want.top, t_key'(o_m_axis_tdata[31:0]));
                        mismatches++;
                    end
                    if (o_m_axis_tdata[32] != want.top_valid) begin
                        $display("%0t: top_valid mismatch: expected %0b, got %0b",
                                 $time, want.top_valid, o_m_axis_tdata[32]);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[41:33] != want.count) begin
                        $display("%0t: count mismatch: expected %0d, got %0d",
                                 $time, want.count, o_m_axis_tdata[41:33]);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[47:42] != 6'd0) begin
                        $display("%0t: tdata padding mismatch: expected 0, got %h",
                                 $time, o_m_axis_tdata[47:42]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid is only dropped on an idle cycle, so it never falls and rises in one step
    task automatic send_op(input t_op op, input t_key key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // mostly small keys so that ties are common, plus full range and extremes
    function automatic t_key pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return t_key'($signed($urandom_range(16)) - 8);
        else if (sel < 75)
            return t_key'($urandom);
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh7FFF_FFFE;
            2: return 32'sh8000_0000;
            3: return 32'sh8000_0001;
            4: return '0;
            default: return -32'sd1;
        endcase
    endfunction

    // starts and ends on an empty heap
    task automatic test_directed();
        send_op(OP_REMOVE, 32'sd123);
        send_op(OP_REMOVE, -32'sd1);
        // both children equal and above the sinking key: left one rises
        send_op(OP_INSERT, 32'sd9);
        send_op(OP_INSERT, 32'sd6);
        send_op(OP_INSERT, 32'sd6);
        send_op(OP_INSERT, 32'sd1);
        repeat (5) send_op(OP_REMOVE, '0);
        // key extremes and a duplicate of the top
        send_op(OP_INSERT, '0);
        send_op(OP_INSERT, 32'sh7FFF_FFFF);
        send_op(OP_INSERT, 32'sh8000_0000);
        send_op(OP_INSERT, -32'sd1);
        send_op(OP_INSERT, 32'sd1);
        send_op(OP_INSERT, 32'sh7FFF_FFFF);
        send_op(OP_INSERT, 32'sh8000_0000);
        repeat (8) send_op(OP_REMOVE, 32'sh5A5A_A5A5);
    endtask

    // fill to capacity, push against the full heap, drain past empty
    task automatic test_fill_drain();
        repeat (CAPACITY) send_op(OP_INSERT, pick_key());
        repeat (3) send_op(OP_INSERT, pick_key());
        repeat (CAPACITY + 2) send_op(OP_REMOVE, t_key'($urandom));
    endtask

    // bursts with a varying insert bias so the count wanders up and down
    task automatic test_random_mix(input int n_items);
        int ins_pct;
        int i;
        ins_pct = 50;
        for (i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: ins_pct = 80;
                    1: ins_pct = 50;
                    default: ins_pct = 25;
                endcase
            end
            if ($urandom_range(99) < ins_pct)
                send_op(OP_INSERT, pick_key());
            else
                send_op(OP_REMOVE, t_key'($urandom));
        end
    endtask

    initial begin
        send_idle_pct  = 6;
        recv_stall_pct = 73;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_drain();
        test_random_mix(450);

        send_idle_pct  = 73;
        recv_stall_pct = 6;
        test_random_mix(450);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(450);

        @(posedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/bmh_pkg.sv
rtl/core/bmh_ram.sv
rtl/core/bmh_datapath.sv
rtl/core/bmh_ctrl.sv
rtl/core/binary_max_heap_priority_queue.sv
bench/testbench.sv
